// File: hdl/deq_pkg.sv
package deq_pkg;

  typedef enum logic [2:0] {
    K_PUSH_FRONT = 3'd0,
    K_PUSH_BACK  = 3'd1,
    K_POP_FRONT  = 3'd2,
    K_POP_BACK   = 3'd3,
    K_CLEAR      = 3'd4,
    K_DELETE     = 3'd5,
    K_READ_ALL   = 3'd6,
    K_READ_N     = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_OUT_RD,
    S_OUT_EMIT,
    S_DEL_RD,
    S_DEL_CMP,
    S_SH_RD,
    S_SH_WR,
    S_RESP
  } state_e;

  localparam int unsigned ValueW = 32;
  localparam int unsigned FillW  = 6;

  typedef struct packed {
    logic [ValueW-1:0] entry_value;
    logic              value_valid;
    status_e           status;
    logic              last;
    logic [FillW-1:0]  fill_count;
  } res_t;

endpackage

// File: hdl/deq_ram.sv
module deq_ram #(
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [deq_pkg::ValueW-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [deq_pkg::ValueW-1:0] rdata_o
);
  import deq_pkg::*;

  logic [ValueW-1:0] mem [DEPTH];
  logic [ValueW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/deq_seq.sv
module deq_seq #(
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  output logic                       req_ready_o,
  input  deq_pkg::kind_e             req_kind_i,
  input  logic [deq_pkg::ValueW-1:0] req_operand_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output deq_pkg::res_t              res_o,
  output logic                       ram_we_o,
  output logic [AW-1:0]              ram_waddr_o,
  output logic [deq_pkg::ValueW-1:0] ram_wdata_o,
  output logic                       ram_re_o,
  output logic [AW-1:0]              ram_raddr_o,
  input  logic [deq_pkg::ValueW-1:0] ram_rdata_i
);
  import deq_pkg::*;

  localparam int SW = CW + 1;

  state_e            state_q, state_d;
  kind_e             kind_q, kind_d;
  logic [ValueW-1:0] opv_q, opv_d;
  logic [AW-1:0]     front_q, front_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     n_q, n_d;
  status_e           stat_q, stat_d;

  logic [CW-1:0] slot_off;
  logic [SW-1:0] slot_sum;
  logic [AW-1:0] slot_addr;
  logic [AW-1:0] front_dec;
  logic [AW-1:0] front_inc;
  logic [SW-1:0] idx_p1;
  logic [SW-1:0] idx_p2;
  logic          empty;
  logic          full;
  logic          hit;
  logic          n_none;
  logic          res_fire;
  logic          out_last;

  // Shared address unit: one offset from the front, wrapped round the store.
  always_comb begin
    slot_off = idx_q;
    unique case (state_q)
      S_EXEC: begin
        priority case (kind_q)
          K_PUSH_BACK: slot_off = count_q;
          K_POP_BACK:  slot_off = count_q - CW'(1);
          default:     slot_off = '0;
        endcase
      end
      S_SH_RD: slot_off = idx_q + CW'(1);
      default: slot_off = idx_q;
    endcase
  end

  assign slot_sum  = SW'(front_q) + SW'(slot_off);
  assign slot_addr = (slot_sum >= SW'(DEPTH)) ? AW'(slot_sum - SW'(DEPTH)) : AW'(slot_sum);
  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
  assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);

  assign idx_p1   = SW'(idx_q) + SW'(1);
  assign idx_p2   = SW'(idx_q) + SW'(2);
  assign empty    = (count_q == '0);
  assign full     = (count_q == CW'(DEPTH));
  assign hit      = (ram_rdata_i == opv_q);
  assign n_none   = opv_q[ValueW-1] || (opv_q == '0);
  assign out_last = (idx_p1 == SW'(n_q));
  assign res_fire = res_valid_o && res_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (kind_q)
          K_PUSH_FRONT, K_PUSH_BACK, K_CLEAR: state_d = S_RESP;
          K_POP_FRONT, K_POP_BACK:            state_d = empty ? S_RESP : S_POP;
          K_DELETE:                           state_d = empty ? S_RESP : S_DEL_RD;
          K_READ_ALL:                         state_d = empty ? S_RESP : S_OUT_RD;
          K_READ_N:  state_d = (empty || n_none) ? S_RESP : S_OUT_RD;
        endcase
      end
      S_POP: begin
        if (res_fire) begin
          state_d = S_IDLE;
        end
      end
      S_OUT_RD: state_d = S_OUT_EMIT;
      S_OUT_EMIT: begin
        if (res_fire) begin
          state_d = out_last ? S_IDLE : S_OUT_RD;
        end
      end
      S_DEL_RD: state_d = S_DEL_CMP;
      S_DEL_CMP: begin
        if (hit) begin
          state_d = (idx_p1 < SW'(count_q)) ? S_SH_RD : S_RESP;
        end else begin
          state_d = (idx_p1 == SW'(count_q)) ? S_RESP : S_DEL_RD;
        end
      end
      S_SH_RD: state_d = S_SH_WR;
      S_SH_WR: state_d = (idx_p2 < SW'(count_q)) ? S_SH_RD : S_RESP;
      S_RESP: begin
        if (res_fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    kind_d      = kind_q;
    opv_d       = opv_q;
    front_d     = front_q;
    count_d     = count_q;
    idx_d       = idx_q;
    n_d         = n_q;
    stat_d      = stat_q;
    req_ready_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = slot_addr;
    ram_wdata_o = opv_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = slot_addr;
    res_valid_o = 1'b0;
    res_o.entry_value = '0;
    res_o.value_valid = 1'b0;
    res_o.status      = stat_q;
    res_o.last        = 1'b1;
    res_o.fill_count  = FillW'(count_q);

    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          kind_d = req_kind_i;
          opv_d  = req_operand_i;
        end
      end
      S_EXEC: begin
        stat_d = ST_OK;
        idx_d  = '0;
        unique case (kind_q)
          K_PUSH_FRONT, K_PUSH_BACK: begin
            if (full) begin
              stat_d = ST_FULL;
            end else begin
              ram_we_o = 1'b1;
              count_d  = count_q + CW'(1);
              if (kind_q == K_PUSH_FRONT) begin
                ram_waddr_o = front_dec;
                front_d     = front_dec;
              end
            end
          end
          K_POP_FRONT, K_POP_BACK: begin
            if (empty) begin
              stat_d = ST_EMPTY;
            end else begin
              ram_re_o = 1'b1;
            end
          end
          K_CLEAR: begin
            count_d = '0;
            front_d = '0;
          end
          K_DELETE: begin
            if (empty) begin
              stat_d = ST_EMPTY;
            end
          end
          K_READ_ALL, K_READ_N: begin
            if (empty) begin
              stat_d = ST_EMPTY;
            end else if (kind_q == K_READ_N && opv_q < ValueW'(count_q)) begin
              n_d = CW'(opv_q);
            end else begin
              n_d = count_q;
            end
          end
        endcase
      end
      S_POP: begin
        res_valid_o       = 1'b1;
        res_o.entry_value = ram_rdata_i;
        res_o.value_valid = 1'b1;
        res_o.status      = ST_OK;
        res_o.fill_count  = FillW'(count_q - CW'(1));
        if (res_fire) begin
          count_d = count_q - CW'(1);
          if (kind_q == K_POP_FRONT) begin
            front_d = front_inc;
          end
        end
      end
      S_OUT_RD: begin
        ram_re_o = 1'b1;
      end
      S_OUT_EMIT: begin
        res_valid_o       = 1'b1;
        res_o.entry_value = ram_rdata_i;
        res_o.value_valid = 1'b1;
        res_o.status      = ST_OK;
        res_o.last        = out_last;
        if (res_fire) begin
          idx_d = idx_q + CW'(1);
        end
      end
      S_DEL_RD: begin
        ram_re_o = 1'b1;
      end
      S_DEL_CMP: begin
        if (hit) begin
          stat_d = ST_OK;
          if (idx_p1 >= SW'(count_q)) begin
            count_d = count_q - CW'(1);
          end
        end else begin
          idx_d = idx_q + CW'(1);
          if (idx_p1 == SW'(count_q)) begin
            stat_d = ST_NOT_FOUND;
          end
        end
      end
      S_SH_RD: begin
        ram_re_o = 1'b1;
      end
      S_SH_WR: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = ram_rdata_i;
        idx_d       = idx_q + CW'(1);
        if (idx_p2 >= SW'(count_q)) begin
          count_d = count_q - CW'(1);
          stat_d  = ST_OK;
        end
      end
      S_RESP: begin
        res_valid_o = 1'b1;
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      front_q <= '0;
      count_q <= '0;
      idx_q   <= '0;
      n_q     <= '0;
      stat_q  <= ST_OK;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
      stat_q  <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    opv_q  <= opv_d;
  end

endmodule

// File: hdl/double_ended_queue_ops_core.sv
// Bounded double-ended queue of signed 32-bit values, one operation per request.
// Slave channel: s_axis_tuser carries the operation kind, s_axis_tdata the operand
// (value to push or delete, or the count for a partial read-out). Master channel:
// one result per request, or one per entry for read-outs, with tlast on the final
// result of each request. Full, empty and not-found cases are reported in tuser.
// A request is taken only while the sequencer is idle. Push, pop, clear and status-only
// results pass through the execute state, then the pop or response state, then the
// output register. A read-out reads (OUT_RD) and emits (OUT_EMIT) one entry at a time
// and takes no new request until its last entry is emitted. A delete reads and compares
// entries (DEL_RD, DEL_CMP) until it finds the value, then reads and writes back each
// later entry (SH_RD, SH_WR) to close the gap. The store's one read port is registered.
// Reset empties the queue at once; no clearing pass is needed because stored
// entries are only read while live. A result waits in the output register while
// the receiver stalls, and the sequencer holds until that register is free.
module double_ended_queue_ops_core #(
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] operand_value
  input  logic [2:0]  s_axis_tuser,  // [2:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [31:0] entry_value, [37:32] fill_count, rest zero
  output logic [2:0]  m_axis_tuser,  // [0] value_valid, [2:1] status
  output logic        m_axis_tlast
);
  import deq_pkg::*;

  logic              res_valid;
  logic              res_ready;
  res_t              res;
  res_t              out_q;
  logic              out_vld_q;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ValueW-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [ValueW-1:0] ram_rdata;

  deq_seq #(.DEPTH(DEPTH)) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_o   (s_axis_tready),
    .req_kind_i    (kind_e'(s_axis_tuser)),
    .req_operand_i (s_axis_tdata),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata)
  );

  deq_ram #(.DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign res_ready = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_q.fill_count, out_q.entry_value};
  assign m_axis_tuser  = {out_q.status, out_q.value_valid};
  assign m_axis_tlast  = out_q.last;

endmodule

// File: hdl/deq_checker.sv
module deq_checker #(
  parameter int DEPTH = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_i,
  input logic        m_axis_tvalid_i,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_i,
  input logic [2:0]  m_axis_tuser_i,
  input logic        m_axis_tlast_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=>
      $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i) && $stable(m_axis_tlast_i))
  else $error("Stalled result changed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_i |=> !s_axis_tready_i)
  else $error("Request taken while the previous one is still in progress.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> (DEPTH > 63) || (m_axis_tdata_i[37:32] <= 7'(DEPTH)))
  else $error("Fill count above the queue depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tuser_i[0] |-> m_axis_tuser_i[2:1] == 2'd0)
  else $error("Entry returned with a failing status.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tlast_i |-> m_axis_tuser_i[0])
  else $error("Non-final result without an entry.");

endmodule

bind double_ended_queue_ops_core deq_checker #(.DEPTH(DEPTH)) u_deq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid),
  .s_axis_tready_i (s_axis_tready),
  .m_axis_tvalid_i (m_axis_tvalid),
  .m_axis_tready_i (m_axis_tready),
  .m_axis_tdata_i  (m_axis_tdata),
  .m_axis_tuser_i  (m_axis_tuser),
  .m_axis_tlast_i  (m_axis_tlast)
);

// File: dv/double_ended_queue_ops_core_test.sv
`timescale 1ns / 1ps

module double_ended_queue_ops_core_test;
  import deq_pkg::*;

  localparam int DEPTH = 32;
  localparam int HoldCycles = 120;

  typedef struct packed {
    kind_e             kind;
    logic [ValueW-1:0] operand;
    logic              typed;
    logic [ValueW-1:0] value;
    logic              valid;
    status_e           status;
    logic [FillW-1:0]  fill;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  logic [ValueW-1:0] model_store [DEPTH];
  int unsigned       model_front;
  int unsigned       model_count;
  res_t              model_results[$];
  res_t              pending_results[$];

  int err_count;
  bit tx_steady;
  bit rx_steady;
  int rx_hold_cycles;

  // Typed rows carry the single result that follows from the row at a glance.
  dir_row_t dir_table [21] = '{
    '{K_POP_FRONT,  32'd0,          1'b1, 32'd0,          1'b0, ST_EMPTY,     6'd0},
    '{K_POP_BACK,   32'd0,          1'b1, 32'd0,          1'b0, ST_EMPTY,     6'd0},
    '{K_DELETE,     32'd5,          1'b1, 32'd0,          1'b0, ST_EMPTY,     6'd0},
    '{K_READ_ALL,   32'd0,          1'b1, 32'd0,          1'b0, ST_EMPTY,     6'd0},
    '{K_READ_N,     32'd5,          1'b1, 32'd0,          1'b0, ST_EMPTY,     6'd0},
    '{K_PUSH_BACK,  32'h7fff_ffff,  1'b1, 32'd0,          1'b0, ST_OK,        6'd1},
    '{K_PUSH_FRONT, 32'h8000_0000,  1'b1, 32'd0,          1'b0, ST_OK,        6'd2},
    '{K_PUSH_BACK,  32'hffff_ffff,  1'b1, 32'd0,          1'b0, ST_OK,        6'd3},
    '{K_PUSH_FRONT, 32'd0,          1'b1, 32'd0,          1'b0, ST_OK,        6'd4},
    '{K_READ_ALL,   32'd0,          1'b0, 32'd0,          1'b0, ST_OK,        6'd0},
    '{K_READ_N,     32'd0,          1'b1, 32'd0,          1'b0, ST_OK,        6'd4},
    '{K_READ_N,     32'h8000_0000,  1'b1, 32'd0,          1'b0, ST_OK,        6'd4},
    '{K_READ_N,     32'hffff_ffff,  1'b1, 32'd0,          1'b0, ST_OK,        6'd4},
    '{K_READ_N,     32'd2,          1'b0, 32'd0,          1'b0, ST_OK,        6'd0},
    '{K_READ_N,     32'h7fff_ffff,  1'b0, 32'd0,          1'b0, ST_OK,        6'd0},
    '{K_DELETE,     32'd12345,      1'b1, 32'd0,          1'b0, ST_NOT_FOUND, 6'd4},
    '{K_DELETE,     32'h7fff_ffff,  1'b1, 32'd0,          1'b0, ST_OK,        6'd3},
    '{K_POP_FRONT,  32'd0,          1'b1, 32'd0,          1'b1, ST_OK,        6'd2},
    '{K_POP_BACK,   32'd0,          1'b1, 32'hffff_ffff,  1'b1, ST_OK,        6'd1},
    '{K_CLEAR,      32'd0,          1'b1, 32'd0,          1'b0, ST_OK,        6'd0},
    '{K_CLEAR,      32'd0,          1'b1, 32'd0,          1'b0, ST_OK,        6'd0}
  };

  double_ended_queue_ops_core #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int unsigned slot_of(int unsigned offset);
    return (model_front + offset) % DEPTH;
  endfunction

  function automatic res_t make_result(logic [ValueW-1:0] value, logic valid, status_e st,
                                       logic fin);
    res_t r;
    r.entry_value = value;
    r.value_valid = valid;
    r.status      = st;
    r.last        = fin;
    r.fill_count  = FillW'(model_count);
    return r;
  endfunction

  function automatic void apply_to_model(kind_e op, logic [ValueW-1:0] operand);
    int unsigned i;
    int unsigned n;
    logic [ValueW-1:0] v;
    model_results.delete();
    case (op)
      K_PUSH_FRONT, K_PUSH_BACK: begin
        if (model_count >= DEPTH) begin
          model_results.push_back(make_result('0, 1'b0, ST_FULL, 1'b1));
        end else begin
          if (op == K_PUSH_FRONT) begin
            model_front = (model_front + DEPTH - 1) % DEPTH;
            model_store[model_front] = operand;
          end else begin
            model_store[slot_of(model_count)] = operand;
          end
          model_count++;
          model_results.push_back(make_result('0, 1'b0, ST_OK, 1'b1));
        end
      end
      K_POP_FRONT, K_POP_BACK: begin
        if (model_count == 0) begin
          model_results.push_back(make_result('0, 1'b0, ST_EMPTY, 1'b1));
        end else begin
          if (op == K_POP_FRONT) begin
            v = model_store[slot_of(0)];
            model_front = slot_of(1);
          end else begin
            v = model_store[slot_of(model_count - 1)];
          end
          model_count--;
          model_results.push_back(make_result(v, 1'b1, ST_OK, 1'b1));
        end
      end
      K_CLEAR: begin
        model_count = 0;
        model_front = 0;
        model_results.push_back(make_result('0, 1'b0, ST_OK, 1'b1));
      end
      K_DELETE: begin
        if (model_count == 0) begin
          model_results.push_back(make_result('0, 1'b0, ST_EMPTY, 1'b1));
        end else begin
          i = 0;
          while (i < model_count && model_store[slot_of(i)] != operand) i++;
          if (i == model_count) begin
            model_results.push_back(make_result('0, 1'b0, ST_NOT_FOUND, 1'b1));
          end else begin
            while (i + 1 < model_count) begin
              model_store[slot_of(i)] = model_store[slot_of(i + 1)];
              i++;
            end
            model_count--;
            model_results.push_back(make_result('0, 1'b0, ST_OK, 1'b1));
          end
        end
      end
      default: begin
        if (model_count == 0) begin
          model_results.push_back(make_result('0, 1'b0, ST_EMPTY, 1'b1));
        end else if (op == K_READ_N && (operand[ValueW-1] || operand == '0)) begin
          model_results.push_back(make_result('0, 1'b0, ST_OK, 1'b1));
        end else begin
          n = model_count;
          if (op == K_READ_N && operand < n) n = operand;
          for (i = 0; i < n; i++) begin
            model_results.push_back(make_result(model_store[slot_of(i)], 1'b1, ST_OK,
                                                i + 1 == n));
          end
        end
      end
    endcase
  endfunction

  task automatic report_error(input string what);
    err_count++;
    if (err_count <= 10) $display("mismatch: %s", what);
  endtask

  always @(posedge clk_i) begin : result_check
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.entry_value = m_axis_tdata[31:0];
      got.fill_count  = m_axis_tdata[37:32];
      got.value_valid = m_axis_tuser[0];
      got.status      = status_e'(m_axis_tuser[2:1]);
      got.last        = m_axis_tlast;
      if (pending_results.size() == 0) begin
        report_error($sformatf("unexpected result value %h valid %b status %0d last %b fill %0d",
                               got.entry_value, got.value_valid, got.status, got.last,
                               got.fill_count));
      end else begin
        want = pending_results.pop_front();
        if (got.entry_value !== want.entry_value || got.value_valid !== want.value_valid ||
            got.status !== want.status || got.last !== want.last ||
            got.fill_count !== want.fill_count || m_axis_tdata[39:38] !== 2'b00) begin
          report_error($sformatf({"expected value %h valid %b status %0d last %b fill %0d, ",
                                  "got value %h valid %b status %0d last %b fill %0d pad %b"},
                                 want.entry_value, want.value_valid, want.status, want.last,
                                 want.fill_count, got.entry_value, got.value_valid,
                                 got.status, got.last, got.fill_count, m_axis_tdata[39:38]));
        end
      end
    end
  end

  initial begin : result_sink
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold_cycles) @(negedge clk_i);
        rx_hold_cycles = 0;
      end
      stall = rx_steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input kind_e op, input logic [ValueW-1:0] operand,
                              input bit typed, input res_t typed_res);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= operand;
    do @(posedge clk_i); while (!s_axis_tready);
    apply_to_model(op, operand);
    if (typed) begin
      pending_results.push_back(typed_res);
    end else begin
      foreach (model_results[i]) pending_results.push_back(model_results[i]);
    end
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  function automatic logic [ValueW-1:0] pick_value();
    logic [ValueW-1:0] v;
    if ($urandom_range(0, 3) == 0) return $urandom();
    v = $urandom_range(0, 11);
    return v - 32'd6;
  endfunction

  function automatic logic [ValueW-1:0] pick_count();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom();
    if (r == 1) return '0;
    return $urandom_range(1, 40);
  endfunction

  function automatic kind_e pick_kind(int push_pct);
    int r;
    if ($urandom_range(0, 99) < push_pct) begin
      return $urandom_range(0, 1) ? K_PUSH_BACK : K_PUSH_FRONT;
    end
    r = $urandom_range(0, 19);
    if (r < 5) return K_POP_FRONT;
    if (r < 10) return K_POP_BACK;
    if (r == 10) return K_CLEAR;
    if (r < 15) return K_DELETE;
    if (r < 17) return K_READ_ALL;
    return K_READ_N;
  endfunction

  task automatic send_random(input int push_pct, input int count);
    kind_e op;
    for (int k = 0; k < count; k++) begin
      op = pick_kind(push_pct);
      send_request(op, (op == K_READ_N) ? pick_count() : pick_value(), 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    res_t typed_res;
    logic [ValueW-1:0] tail_value;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = K_PUSH_FRONT;
    err_count      = 0;
    tx_steady      = 1'b0;
    rx_steady      = 1'b0;
    rx_hold_cycles = 0;
    model_front    = 0;
    model_count    = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_table[i]) begin
      typed_res.entry_value = dir_table[i].value;
      typed_res.value_valid = dir_table[i].valid;
      typed_res.status      = dir_table[i].status;
      typed_res.last        = 1'b1;
      typed_res.fill_count  = dir_table[i].fill;
      send_request(dir_table[i].kind, dir_table[i].operand, dir_table[i].typed, typed_res);
    end

    // Fill to the limit, then push at both ends, read all and part, delete the tail, pop.
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    tail_value = '0;
    for (int k = 0; k < DEPTH; k++) begin
      tail_value = $urandom();
      send_request(K_PUSH_BACK, tail_value, 1'b0, '0);
    end
    send_request(K_PUSH_FRONT, $urandom(), 1'b0, '0);
    send_request(K_PUSH_BACK, $urandom(), 1'b0, '0);
    send_request(K_READ_ALL, '0, 1'b0, '0);
    send_request(K_READ_N, DEPTH - 1, 1'b0, '0);
    send_request(K_DELETE, tail_value, 1'b0, '0);
    send_request(K_POP_FRONT, '0, 1'b0, '0);
    wait_drained();

    tx_steady = 1'b0;
    rx_steady = 1'b0;
    send_random(80, 50);
    wait_drained();

    // The receiver holds off while requests keep coming, so the input backs up.
    tx_steady = 1'b1;
    rx_hold_cycles = HoldCycles;
    send_random(50, 45);

    tx_steady = 1'b0;
    rx_steady = 1'b1;
    send_random(25, 40);

    rx_steady = 1'b0;
    send_random(55, 40);

    wait_drained();
    repeat (4 * DEPTH + 16) @(posedge clk_i);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
